>>> rtl/rtu_pkg.sv
`default_nettype none
package rtu_pkg;

    localparam int FRAME_BYTES_DEF = 256;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RX_BYTE = 2'd1;
    localparam logic [1:0] ACT_TX_BYTE = 2'd2;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_INIT  = 3'd1;
    localparam logic [2:0] MODE_IDLE  = 3'd2;
    localparam logic [2:0] MODE_TX    = 3'd3;
    localparam logic [2:0] MODE_RX    = 3'd4;
    localparam logic [2:0] MODE_WAIT  = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [15:0] CHAR_GAP_RESET  = 16'd2;
    localparam logic [15:0] FRAME_GAP_RESET = 16'd4;

    localparam logic [1:0] REG_CHAR_GAP  = 2'd0;
    localparam logic [1:0] REG_FRAME_GAP = 2'd1;

    // Decoded request handed from the front end to the execution side.
    typedef struct packed {
        logic       is_tick;
        logic       is_rx;
        logic       is_pl;
        logic       last;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_done;
        logic       frame_pass;
        logic [7:0] payload_length;
        logic [2:0] link_state;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rtu_frame_timing_crc_link.sv
// RTU link controller: frame timing and CRC-16 for a half-duplex serial line.
// Input stream (s_axis): tuser is the request kind (0 tick, 1 byte taken from
// the line, 2 payload byte to send), tdata the byte, tlast the final payload
// byte of a frame to send. Every request gives exactly one result on m_axis:
// the byte driven to the line on this tick, a received frame's end with its
// CRC verdict and payload length, and the link state after the request.
// A two-entry request queue feeds the execution side, which handles one
// request per clock unless the receiver stalls; results sit in an output
// register, loaded when the execution side takes the request from the queue.
// The per-cycle path is set by the byte-wide CRC update and the transmit
// store, whose read is registered and addressed with the next position.
// When the receiver stalls, the output register holds its result and the
// queue fills; s_axis_tready falls once both queue entries are occupied.
// Reset (synchronous, active low) returns the link to the start state, gap
// registers to 2 and 4 ticks, and empties queue and output; the transmit
// store needs no clearing. Gap registers are written through the cfg port
// by the user while the block is idle; the block itself does not enforce it.
`default_nettype none
module rtu_frame_timing_crc_link
    import rtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_addr,
    input  wire [15:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire  [1:0]  s_axis_tuser,   // action
    input  wire         s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tx_valid, tx_byte[8:1], frame_done, frame_pass, payload_length[18:11],
    // link_state[21:19], zero fill
    output logic [23:0] m_axis_tdata
);

    logic    w_q_valid, w_take;
    t_item   w_item;
    t_result w_res;

    rtu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_action(s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_valid (w_q_valid),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    rtu_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (w_q_valid),
        .o_take     (w_take),
        .i_item     (w_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.link_state, w_res.payload_length,
                           w_res.frame_pass, w_res.frame_done, w_res.tx_byte,
                           w_res.tx_valid};

endmodule
`default_nettype wire

>>> rtl/rtu_ram.sv
`default_nettype none
module rtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/rtu_front.sv
`default_nettype none
module rtu_front
    import rtu_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [1:0]  i_action,
    input  wire [7:0]  i_data,
    input  wire        i_last,
    output logic       o_valid,
    input  wire        i_take,
    output t_item      o_item
);

    // Two-entry queue of decoded requests.
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push, w_pop;

    always_comb begin
        w_item.is_tick = (i_action == ACT_TICK);
        w_item.is_rx   = (i_action == ACT_RX_BYTE);
        w_item.is_pl   = (i_action == ACT_TX_BYTE);
        w_item.last    = i_last;
        w_item.data    = i_data;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

>>> rtl/rtu_back.sv
`default_nettype none
module rtu_back
    import rtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_addr,
    input  wire [15:0] i_cfg_wdata,
    input  wire        i_valid,
    output logic       o_take,
    input  t_item      i_item,
    output logic       o_valid,
    input  wire        i_ready,
    output t_result    o_res
);

    localparam int CW = $clog2(FRAME_BYTES + 2);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] RX_MAX   = CW'(FRAME_BYTES);
    localparam logic [CW-1:0] DATA_MAX = CW'(FRAME_BYTES - 2);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);

    logic [15:0]   r_cg_ticks, r_fg_ticks;
    logic [2:0]    r_mode, n_mode;
    logic [15:0]   r_cg, n_cg, r_fg, n_fg;
    logic [CW-1:0] r_rxc, n_rxc;
    logic [15:0]   r_rxcrc, n_rxcrc;
    logic          r_late, n_late;
    logic [CW-1:0] r_dfill, n_dfill, r_pos, n_pos;
    logic [15:0]   r_tcrc, n_tcrc, r_fcs, n_fcs;
    logic          r_pend, n_pend;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;
    t_result       n_res;
    logic          w_fire;
    logic          w_we;
    logic [7:0]    w_ram_q, w_mem_byte;
    logic [15:0]   w_cg_d, w_fg_d, w_crc;
    logic [CW-1:0] w_fill;

    assign o_take = i_valid && (!o_valid || i_ready);
    assign w_fire = o_take;

    rtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_dfill[AW-1:0]),
        .i_wdata(i_item.data),
        .i_raddr(n_pos[AW-1:0]),
        .o_rdata(w_ram_q)
    );

    // The store reads before it writes, so a byte written to the address being
    // fetched is forwarded from a side register.
    assign w_mem_byte = r_byp_hit ? r_byp_data : w_ram_q;

    always_comb begin
        n_mode  = r_mode;
        n_cg    = r_cg;
        n_fg    = r_fg;
        n_rxc   = r_rxc;
        n_rxcrc = r_rxcrc;
        n_late  = r_late;
        n_dfill = r_dfill;
        n_pos   = r_pos;
        n_tcrc  = r_tcrc;
        n_fcs   = r_fcs;
        n_pend  = r_pend;
        w_we    = 1'b0;
        n_res   = '0;
        w_cg_d  = (r_cg != 16'd0) ? r_cg - 16'd1 : r_cg;
        w_fg_d  = (r_fg != 16'd0) ? r_fg - 16'd1 : r_fg;
        w_fill  = r_dfill + (r_pend ? CNT_TWO : '0);
        w_crc   = crc_step(i_item.is_rx ? r_rxcrc : r_tcrc, i_item.data);
        if (w_fire) begin
            if (i_item.is_rx) begin
                case (r_mode)
                    MODE_INIT: begin
                        n_fg = r_fg_ticks;
                    end
                    MODE_IDLE: begin
                        n_late  = 1'b0;
                        n_rxc   = CNT_ONE;
                        n_rxcrc = crc_step(CRC_INIT, i_item.data);
                        n_cg    = r_cg_ticks;
                        n_fg    = r_fg_ticks;
                        n_mode  = MODE_RX;
                    end
                    MODE_RX: begin
                        if (r_rxc <= RX_MAX) begin
                            n_rxc = r_rxc + CNT_ONE;
                        end
                        n_rxcrc = w_crc;
                        n_cg    = r_cg_ticks;
                        n_fg    = r_fg_ticks;
                    end
                    MODE_WAIT: begin
                        n_late = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (i_item.is_pl) begin
                if (!r_pend) begin
                    if (r_dfill < DATA_MAX) begin
                        w_we    = 1'b1;
                        n_dfill = r_dfill + CNT_ONE;
                        n_tcrc  = w_crc;
                    end
                    if (i_item.last) begin
                        n_fcs  = (r_dfill < DATA_MAX) ? w_crc : r_tcrc;
                        n_tcrc = CRC_INIT;
                        n_pend = 1'b1;
                    end
                end
            end else if (i_item.is_tick) begin
                n_cg = w_cg_d;
                n_fg = w_fg_d;
                case (r_mode)
                    MODE_INIT: begin
                        if (w_fg_d == 16'd0) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_IDLE: begin
                        if (r_pend) begin
                            n_mode = MODE_TX;
                        end
                    end
                    MODE_TX: begin
                        if (r_pos < w_fill) begin
                            n_res.tx_valid = 1'b1;
                            if (r_pos < r_dfill) begin
                                n_res.tx_byte = w_mem_byte;
                            end else if (r_pos == r_dfill) begin
                                n_res.tx_byte = r_fcs[7:0];
                            end else begin
                                n_res.tx_byte = r_fcs[15:8];
                            end
                            n_pos = r_pos + CNT_ONE;
                        end
                        if (r_pend && n_pos >= w_fill) begin
                            n_pend  = 1'b0;
                            n_dfill = '0;
                            n_pos   = '0;
                            n_fg    = r_fg_ticks;
                        end else if (!r_pend && w_fg_d == 16'd0) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_RX: begin
                        if (w_cg_d == 16'd0) begin
                            n_mode = MODE_WAIT;
                        end
                    end
                    MODE_WAIT: begin
                        if (w_fg_d == 16'd0) begin
                            n_res.frame_done = 1'b1;
                            if (!r_late && r_rxc >= CNT_TWO && r_rxc <= RX_MAX
                                && r_rxcrc == 16'd0) begin
                                n_res.frame_pass     = 1'b1;
                                n_res.payload_length = 8'(r_rxc - CNT_TWO);
                            end
                            n_rxc   = '0;
                            n_rxcrc = CRC_INIT;
                            n_late  = 1'b0;
                            n_fg    = r_fg_ticks;
                            n_mode  = MODE_IDLE;
                        end
                    end
                    default: begin
                        n_rxc   = '0;
                        n_rxcrc = CRC_INIT;
                        n_late  = 1'b0;
                        n_cg    = 16'd0;
                        n_fg    = r_fg_ticks;
                        n_dfill = '0;
                        n_pos   = '0;
                        n_tcrc  = CRC_INIT;
                        n_pend  = 1'b0;
                        n_mode  = MODE_INIT;
                    end
                endcase
            end
        end
        n_res.link_state = n_mode;
    end

    always_ff @(posedge i_clk) begin
        r_byp_hit  <= w_we && (r_dfill[AW-1:0] == n_pos[AW-1:0]);
        r_byp_data <= i_item.data;
        r_fcs      <= n_fcs;
        if (w_fire) begin
            o_res <= n_res;
        end
        if (!i_rst_n) begin
            r_cg_ticks <= CHAR_GAP_RESET;
            r_fg_ticks <= FRAME_GAP_RESET;
            r_mode     <= MODE_START;
            r_cg       <= 16'd0;
            r_fg       <= 16'd0;
            r_rxc      <= '0;
            r_rxcrc    <= CRC_INIT;
            r_late     <= 1'b0;
            r_dfill    <= '0;
            r_pos      <= '0;
            r_tcrc     <= CRC_INIT;
            r_pend     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == REG_CHAR_GAP) begin
                r_cg_ticks <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == REG_FRAME_GAP) begin
                r_fg_ticks <= i_cfg_wdata;
            end
            r_mode  <= n_mode;
            r_cg    <= n_cg;
            r_fg    <= n_fg;
            r_rxc   <= n_rxc;
            r_rxcrc <= n_rxcrc;
            r_late  <= n_late;
            r_dfill <= n_dfill;
            r_pos   <= n_pos;
            r_tcrc  <= n_tcrc;
            r_pend  <= n_pend;
            if (w_fire) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/rtu_checker.sv
`default_nettype none
module rtu_checker
    import rtu_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A good frame verdict only comes with a frame end.
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9])
        else $error("frame_pass without frame_done");

    // A length is reported only for a good frame.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18:11] != 8'd0 |-> m_axis_tdata[10])
        else $error("payload length on a bad frame");

    // A frame ends only in the idle state, and nothing is sent at that time.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[21:19] == MODE_IDLE
        && !m_axis_tdata[0])
        else $error("frame end outside idle");

endmodule

bind rtu_frame_timing_crc_link rtu_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
